FILE: src/jsu_pkg.sv
package jsu_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_BADESC  = 3'd3;
  localparam logic [2:0] ST_BADHEX  = 3'd4;
  localparam logic [2:0] ST_NOLOW   = 3'd5;
  localparam logic [2:0] ST_BADLOW  = 3'd6;
  localparam logic [2:0] ST_UNTERM  = 3'd7;

  typedef enum logic [1:0] {
    JOB_RAW  = 2'd0,
    JOB_CP   = 2'd1,
    JOB_STAT = 2'd2
  } job_kind_e;

  // One queued unit of work: a raw byte, a code point to encode, or a status.
  typedef struct packed {
    job_kind_e   kind;
    logic [20:0] cp;
    logic [2:0]  status;
  } job_t;

endpackage

FILE: src/json_string_unescape_utf8.sv
// A result byte passes through the job queue and then the output register on its way out.
// Throughput: one input byte per cycle unless the queue is full; one result byte per cycle
// unless out_stall_i is high, so the bytes of a \u escape, up to four, leave one after another.
// A four-entry job queue between decoder and encoder absorbs those bursts.
// Reset (rst_ni low, asynchronous) returns the decoder to idle and empties queue and output.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic accept, push, pop, q_valid, q_full;
  job_t push_job, head_job;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .job_o          (push_job)
  );

  jsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && accept),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (q_valid),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && accept) |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job queue read while empty");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DATA) |-> (last_o && out_byte_o == 8'd0))
    else $error("status item not a lone final item");

  a_multi_byte_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (out_valid_o && status_o == ST_DATA))
    else $error("UTF-8 sequence broken up");

endmodule

FILE: src/jsu_front.sv
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BODY   = 3'd1,
    PH_ESC    = 3'd2,
    PH_HEX    = 3'd3,
    PH_LOWBS  = 3'd4,
    PH_LOWU   = 3'd5,
    PH_LOWHEX = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  high_q, high_d;

  logic        dig_ok;
  logic [3:0]  dig;
  logic [15:0] acc_next;
  logic [7:0]  b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_cnt_q <= 2'd0;
      acc_q     <= 16'd0;
      high_q    <= 10'd0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
      high_q    <= high_d;
    end
  end

  always_comb begin
    b = in_byte_i;
    dig_ok = 1'b1;
    dig = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dig = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dig = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      dig = 4'(b - 8'h37);
    end else begin
      dig_ok = 1'b0;
    end
    if (end_of_input_i) begin
      dig_ok = 1'b0;
    end
    acc_next = {acc_q[11:0], dig};
  end

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    acc_d     = acc_q;
    high_d    = high_q;
    push_o    = 1'b0;
    job_o     = '{kind: JOB_STAT, cp: 21'd0, status: ST_DATA};

    case (phase_q)
      PH_BODY: begin
        if (end_of_input_i) begin
          push_o = 1'b1;
          job_o.status = ST_UNTERM;
          phase_d = PH_IDLE;
        end else if (b == 8'h22) begin
          push_o = 1'b1;
          job_o.status = ST_CLOSED;
          phase_d = PH_IDLE;
        end else if (b == 8'h5C) begin
          phase_d = PH_ESC;
        end else begin
          push_o = 1'b1;
          job_o.kind = JOB_RAW;
          job_o.cp = {13'd0, b};
        end
      end
      PH_ESC: begin
        push_o = 1'b1;
        job_o.kind = JOB_RAW;
        phase_d = PH_BODY;
        if (end_of_input_i) begin
          job_o.kind = JOB_STAT;
          job_o.status = ST_UNTERM;
          phase_d = PH_IDLE;
        end else begin
          case (b)
            8'h22, 8'h5C, 8'h2F: job_o.cp = {13'd0, b};
            8'h62: job_o.cp = 21'h08;
            8'h66: job_o.cp = 21'h0C;
            8'h6E: job_o.cp = 21'h0A;
            8'h72: job_o.cp = 21'h0D;
            8'h74: job_o.cp = 21'h09;
            8'h75: begin
              push_o = 1'b0;
              phase_d = PH_HEX;
              hex_cnt_d = 2'd0;
              acc_d = 16'd0;
            end
            default: begin
              job_o.kind = JOB_STAT;
              job_o.status = ST_BADESC;
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      PH_HEX, PH_LOWHEX: begin
        if (!dig_ok) begin
          push_o = 1'b1;
          job_o.status = (phase_q == PH_HEX) ? ST_BADHEX : ST_BADLOW;
          phase_d = PH_IDLE;
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
        end else if (hex_cnt_q != 2'd3) begin
          hex_cnt_d = hex_cnt_q + 2'd1;
          acc_d = acc_next;
        end else begin
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
          if (phase_q == PH_HEX) begin
            if (acc_next[15:10] == 6'b110110) begin
              high_d = acc_next[9:0];
              phase_d = PH_LOWBS;
            end else begin
              push_o = 1'b1;
              job_o.kind = JOB_CP;
              job_o.cp = {5'd0, acc_next};
              phase_d = PH_BODY;
            end
          end else begin
            push_o = 1'b1;
            if (acc_next[15:10] == 6'b110111) begin
              // Surrogate pair: 0x10000 plus the twenty payload bits.
              job_o.kind = JOB_CP;
              job_o.cp = 21'h10000 + {1'b0, high_q, acc_next[9:0]};
              phase_d = PH_BODY;
            end else begin
              job_o.status = ST_BADLOW;
              phase_d = PH_IDLE;
            end
          end
        end
      end
      PH_LOWBS: begin
        if (end_of_input_i || b != 8'h5C) begin
          push_o = 1'b1;
          job_o.status = ST_NOLOW;
          phase_d = PH_IDLE;
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
        end else begin
          phase_d = PH_LOWU;
        end
      end
      PH_LOWU: begin
        if (end_of_input_i || b != 8'h75) begin
          push_o = 1'b1;
          job_o.status = ST_NOLOW;
          phase_d = PH_IDLE;
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
        end else begin
          phase_d = PH_LOWHEX;
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
        end
      end
      default: begin
        if (!end_of_input_i && b == 8'h22) begin
          phase_d = PH_BODY;
        end else begin
          push_o = 1'b1;
          job_o.status = ST_NOQUOTE;
          phase_d = PH_IDLE;
          hex_cnt_d = 2'd0;
          acc_d = 16'd0;
        end
      end
    endcase
  end

endmodule

FILE: src/jsu_fifo.sv
module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t wdata_i,
  input  logic          pop_i,
  output jsu_pkg::job_t rdata_o,
  output logic          valid_o,
  output logic          full_o
);
  import jsu_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));

endmodule

FILE: src/jsu_back.sv
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jsu_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    status_o,
  output logic          last_o
);
  import jsu_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic [2:0] status_q;
  logic       last_q;
  logic [1:0] idx_q;

  logic [1:0] cnt_m1;
  logic [7:0] bytes [4];
  logic       load, is_last;
  logic [20:0] cp;

  // Lay out the UTF-8 sequence of the head job, first byte in slot 0.
  always_comb begin
    cp = job_i.cp;
    bytes[0] = 8'd0;
    bytes[1] = 8'd0;
    bytes[2] = 8'd0;
    bytes[3] = 8'd0;
    cnt_m1 = 2'd0;
    case (job_i.kind)
      JOB_RAW: bytes[0] = cp[7:0];
      JOB_CP: begin
        if (cp < 21'h80) begin
          bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
          cnt_m1 = 2'd1;
          bytes[0] = {3'b110, cp[10:6]};
          bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
          cnt_m1 = 2'd2;
          bytes[0] = {4'b1110, cp[15:12]};
          bytes[1] = {2'b10, cp[11:6]};
          bytes[2] = {2'b10, cp[5:0]};
        end else begin
          cnt_m1 = 2'd3;
          bytes[0] = {5'b11110, cp[20:18]};
          bytes[1] = {2'b10, cp[17:12]};
          bytes[2] = {2'b10, cp[11:6]};
          bytes[3] = {2'b10, cp[5:0]};
        end
      end
      default: bytes[0] = 8'd0;
    endcase
  end

  assign load    = job_valid_i && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == cnt_m1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= bytes[idx_q];
      status_q <= (job_i.kind == JOB_STAT) ? job_i.status : ST_DATA;
      last_q   <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule
